// File: rtl/scc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants of the set-associative LRU cache classifier.
// ----------------------------------------------------------------------------
package scc_pkg;

	// field widths
	localparam int SET_IDX_W = 8;
	localparam int TAG_W     = 32;
	localparam int CNT_W     = 32;
	localparam int WAYS_REG_W = 4;
	localparam int SETS_REG_W = 9;
	localparam int CFG_DATA_W = 9;

	// default geometry
	localparam int DEF_SETS = 256;
	localparam int DEF_WAYS = 8;

	// configuration register reset values
	localparam logic [WAYS_REG_W-1:0] WAYS_RST = 4'd8;
	localparam logic [SETS_REG_W-1:0] SETS_RST = 9'd256;

	// configuration register indexes
	typedef enum logic {
		CFG_WAYS = 1'b0,
		CFG_SETS = 1'b1
	} scc_cfg_idx_t;

	// access classification
	typedef enum logic [1:0] {
		OUT_HIT      = 2'd0,
		OUT_COLD     = 2'd1,
		OUT_CONFLICT = 2'd2,
		OUT_CAPACITY = 2'd3
	} scc_outcome_t;

	// lookup result of one set row
	typedef struct packed {
		logic hit;
		logic cold;
		logic evict;
		logic mark_full;
	} scc_lookup_t;

	// running totals
	typedef struct packed {
		logic [CNT_W-1:0] accesses;
		logic [CNT_W-1:0] capacity;
		logic [CNT_W-1:0] conflict;
		logic [CNT_W-1:0] cold;
		logic [CNT_W-1:0] hits;
	} scc_counts_t;

endpackage

// File: rtl/scc_row_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_row_update
// Tag lookup and true-LRU update of one set row: hit, fill of a free way,
// or eviction of the oldest way.
// ----------------------------------------------------------------------------
module scc_row_update
	import scc_pkg::*;
#(
	parameter int WAYS = DEF_WAYS,
	localparam int AW = (WAYS > 1) ? $clog2(WAYS) : 1,
	localparam int FW = $clog2(WAYS + 1)
) (
	input  logic [FW-1:0]         fill_in,
	input  logic                  full_in,
	input  logic [WAYS*AW-1:0]    ages_in,
	input  logic [WAYS*TAG_W-1:0] tags_in,
	input  logic [TAG_W-1:0]      tag,
	input  logic [FW-1:0]         act_ways,
	output logic [FW-1:0]         fill_out,
	output logic                  full_out,
	output logic [WAYS*AW-1:0]    ages_out,
	output logic [WAYS*TAG_W-1:0] tags_out,
	output scc_lookup_t           lk
);

	logic [WAYS-1:0] in_use;
	logic [WAYS-1:0] match;
	logic [WAYS-1:0] oldest;
	logic [AW-1:0]   hit_way;
	logic [AW-1:0]   victim;
	logic [AW-1:0]   hit_age;
	logic [AW-1:0]   top_age;
	logic            hit;
	logic            cold;
	logic            evict;

	// per-way compares; valid ways are always 0 .. fill-1
	always_comb begin
		top_age = AW'(fill_in - 1'b1);
		for (int w = 0; w < WAYS; w++) begin
			in_use[w] = (FW'(w) < fill_in);
			match[w]  = in_use[w] && (tags_in[w*TAG_W +: TAG_W] == tag);
			oldest[w] = in_use[w] && (ages_in[w*AW +: AW] == top_age);
		end
	end

	// lowest matching way and lowest oldest way
	always_comb begin
		hit_way = '0;
		victim  = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = AW'(w);
			end
			if (oldest[w]) begin
				victim = AW'(w);
			end
		end
	end

	assign hit     = |match;
	assign cold    = !hit && (fill_in < act_ways);
	assign evict   = !hit && !cold;
	assign hit_age = ages_in[hit_way*AW +: AW];

	// new ages and tags
	always_comb begin
		ages_out = ages_in;
		tags_out = tags_in;
		for (int w = 0; w < WAYS; w++) begin
			if (hit) begin
				if (in_use[w] && (ages_in[w*AW +: AW] < hit_age)) begin
					ages_out[w*AW +: AW] = ages_in[w*AW +: AW] + 1'b1;
				end
				if (AW'(w) == hit_way) begin
					ages_out[w*AW +: AW] = '0;
				end
			end else if (cold) begin
				if (in_use[w]) begin
					ages_out[w*AW +: AW] = ages_in[w*AW +: AW] + 1'b1;
				end
				if (FW'(w) == fill_in) begin
					ages_out[w*AW +: AW]     = '0;
					tags_out[w*TAG_W +: TAG_W] = tag;
				end
			end else begin
				if (in_use[w]) begin
					ages_out[w*AW +: AW] = ages_in[w*AW +: AW] + 1'b1;
				end
				if (AW'(w) == victim) begin
					ages_out[w*AW +: AW]     = '0;
					tags_out[w*TAG_W +: TAG_W] = tag;
				end
			end
		end
	end

	assign fill_out     = cold ? (fill_in + 1'b1) : fill_in;
	assign full_out     = full_in | evict;
	assign lk.hit       = hit;
	assign lk.cold      = cold;
	assign lk.evict     = evict;
	assign lk.mark_full = evict & ~full_in;

endmodule

// File: rtl/scc_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_stats
// Miss classification, full-set count and saturating running totals.
// ----------------------------------------------------------------------------
module scc_stats
	import scc_pkg::*;
#(
	parameter int SETS = DEF_SETS,
	localparam int FSW = $clog2(SETS + 1),
	localparam int CMPW = (FSW > SETS_REG_W) ? FSW : SETS_REG_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  upd,
	input  scc_lookup_t           lk,
	input  logic [SETS_REG_W-1:0] sets_in_use,
	output scc_outcome_t          outcome,
	output scc_counts_t           counts
);

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	logic [FSW-1:0] full_sets_q;
	logic [FSW-1:0] full_sets_nx;
	logic           capacity;
	scc_outcome_t   outcome_q;
	scc_counts_t    counts_q;

	assign full_sets_nx = full_sets_q + FSW'(lk.mark_full);
	assign capacity     = (CMPW'(full_sets_nx) >= CMPW'(sets_in_use));

	// classify and count on each completed access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_sets_q <= '0;
			counts_q    <= '0;
			outcome_q   <= OUT_HIT;
		end else if (upd) begin
			full_sets_q <= full_sets_nx;
			if (counts_q.accesses != CNT_MAX) begin
				counts_q.accesses <= counts_q.accesses + 1'b1;
			end
			if (lk.hit) begin
				outcome_q <= OUT_HIT;
				if (counts_q.hits != CNT_MAX) counts_q.hits <= counts_q.hits + 1'b1;
			end else if (lk.cold) begin
				outcome_q <= OUT_COLD;
				if (counts_q.cold != CNT_MAX) counts_q.cold <= counts_q.cold + 1'b1;
			end else if (lk.evict && capacity) begin
				outcome_q <= OUT_CAPACITY;
				if (counts_q.capacity != CNT_MAX) begin
					counts_q.capacity <= counts_q.capacity + 1'b1;
				end
			end else begin
				outcome_q <= OUT_CONFLICT;
				if (counts_q.conflict != CNT_MAX) begin
					counts_q.conflict <= counts_q.conflict + 1'b1;
				end
			end
		end
	end

	assign outcome = outcome_q;
	assign counts  = counts_q;

endmodule

// File: rtl/set_assoc_lru_cache_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_classifier_core
// Set-associative tag store with true LRU that classifies each access as a
// hit, cold, conflict or capacity miss and keeps saturating totals.
// ----------------------------------------------------------------------------
// Each access reads its set row (tags, LRU ages, fill count and full mark)
// from the single-port row memory into a register, then updates the row,
// writes it back and loads the result register. A new access is taken once
// the previous row has been written back; a waiting result does not block
// the next read, only its write-back. After reset the row memory is cleared
// one set per cycle, all SETS sets, while s_axis_tready stays low;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_classifier_core
	import scc_pkg::*;
#(
	parameter int SETS = DEF_SETS,
	parameter int WAYS = DEF_WAYS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_wr_en,
	input  logic                  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// access stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [39:0]           s_axis_tdata,  // set_index[7:0], tag[39:8]
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// outcome[1:0], hits_so_far[33:2], cold_so_far[65:34],
	// conflict_so_far[97:66], capacity_so_far[129:98],
	// accesses_so_far[161:130], zero[167:162]
	output logic [167:0]          m_axis_tdata
);

	localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int AW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int FW = $clog2(WAYS + 1);
	localparam int TAGS_W = WAYS * TAG_W;
	localparam int AGES_W = WAYS * AW;
	localparam int ROW_W = TAGS_W + AGES_W + FW + 1;
	localparam int RECIP_SH = 16;
	localparam int RECIP_W = RECIP_SH + 1;
	localparam int PROD_W = SET_IDX_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SH) + SETS - 1) / SETS);
	localparam logic [SET_IDX_W-1:0] SETS_LO = SET_IDX_W'(SETS);

	// set index modulo SETS: identity when SETS covers the index range,
	// otherwise quotient by reciprocal multiply, then one subtract
	function automatic logic [SW-1:0] wrap_set(input logic [SET_IDX_W-1:0] v);
		logic [PROD_W-1:0]    prod;
		logic [SET_IDX_W-1:0] quo;
		logic [SET_IDX_W-1:0] rem;
		prod = PROD_W'(v) * PROD_W'(RECIP);
		quo  = prod[RECIP_SH +: SET_IDX_W];
		rem  = v - quo * SETS_LO;
		if (SETS >= (1 << SET_IDX_W)) begin
			rem = v;
		end
		return SW'(rem);
	endfunction

	logic [WAYS_REG_W-1:0] ways_q;
	logic [SETS_REG_W-1:0] sets_q;
	logic [FW-1:0]         act_ways;

	logic                  clr_active_q;
	logic [SW-1:0]         clr_ptr_q;

	logic [ROW_W-1:0]      row_mem [SETS];
	logic [ROW_W-1:0]      rd_q;
	logic [ROW_W-1:0]      wr_row;
	logic                  wr_en;
	logic [SW-1:0]         wr_addr;

	logic                  v_s1;
	logic [SW-1:0]         idx_s1;
	logic [TAG_W-1:0]      tag_s1;

	logic                  out_valid_q;
	logic                  in_acc;
	logic                  done;

	logic [FW-1:0]         fill_out;
	logic                  full_out;
	logic [AGES_W-1:0]     ages_out;
	logic [TAGS_W-1:0]     tags_out;
	scc_lookup_t           lk;
	scc_outcome_t          outcome;
	scc_counts_t           counts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q <= WAYS_RST;
			sets_q <= SETS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_WAYS: ways_q <= cfg_wdata[WAYS_REG_W-1:0];
				CFG_SETS: sets_q <= cfg_wdata[SETS_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// zero means one way, above WAYS means WAYS
	always_comb begin
		if (ways_q == '0) begin
			act_ways = FW'(1);
		end else if (32'(ways_q) > WAYS) begin
			act_ways = FW'(WAYS);
		end else begin
			act_ways = FW'(ways_q);
		end
	end

	// handshake
	assign s_axis_tready = ~clr_active_q & ~v_s1;
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign done          = v_s1 & (~out_valid_q | m_axis_tready);

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_ptr_q    <= '0;
		end else if (clr_active_q) begin
			clr_ptr_q <= clr_ptr_q + 1'b1;
			if (clr_ptr_q == SW'(SETS - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// stage 1 holds the access while its row is read and updated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (done) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_s1 <= wrap_set(s_axis_tdata[SET_IDX_W-1:0]);
			tag_s1 <= s_axis_tdata[SET_IDX_W +: TAG_W];
		end
	end

	// row memory: full mark, fill count, ages, tags
	assign wr_en   = clr_active_q | done;
	assign wr_addr = clr_active_q ? clr_ptr_q : idx_s1;
	assign wr_row  = clr_active_q ? '0 : {full_out, fill_out, ages_out, tags_out};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem[wr_addr] <= wr_row;
		end
		if (in_acc) begin
			rd_q <= row_mem[wrap_set(s_axis_tdata[SET_IDX_W-1:0])];
		end
	end

	// lookup and LRU update
	scc_row_update #(
		.WAYS(WAYS)
	) u_row_update (
		.fill_in  (rd_q[TAGS_W+AGES_W +: FW]),
		.full_in  (rd_q[ROW_W-1]),
		.ages_in  (rd_q[TAGS_W +: AGES_W]),
		.tags_in  (rd_q[TAGS_W-1:0]),
		.tag      (tag_s1),
		.act_ways (act_ways),
		.fill_out (fill_out),
		.full_out (full_out),
		.ages_out (ages_out),
		.tags_out (tags_out),
		.lk       (lk)
	);

	// classification and totals
	scc_stats #(
		.SETS(SETS)
	) u_stats (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (done),
		.lk          (lk),
		.sets_in_use (sets_q),
		.outcome     (outcome),
		.counts      (counts)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, counts.accesses, counts.capacity, counts.conflict,
		counts.cold, counts.hits, outcome};

endmodule
